// ===== hdl/tbeq_pkg.sv =====
package tbeq_pkg;

  localparam int COEF_W         = 32;
  localparam int COEF_FRAC_BITS = 28;
  localparam int NUM_COEFS      = 7;

  // Filter outputs carry 16 fraction bits and saturate at 40 bits.
  localparam int Y_W    = 40;
  localparam int Y_FRAC = 16;
  localparam int SUM_W  = Y_W + 2;

  localparam int ADDR_W     = 5;
  localparam int APB_DATA_W = 32;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [Y_W-1:0]    acc_t;

  typedef enum logic [2:0] {
    REG_LOW_NUM  = 3'd0,
    REG_LOW_FB   = 3'd1,
    REG_HIGH_NUM = 3'd2,
    REG_HIGH_FB  = 3'd3,
    REG_MID_NUM  = 3'd4,
    REG_MID_FB1  = 3'd5,
    REG_MID_FB2  = 3'd6
  } reg_idx_e;

  localparam coef_t COEF_RESET [NUM_COEFS] = '{
    32'sd3468455,
    -32'sd261498816,
    32'sd255079456,
    -32'sd241723443,
    32'sd13183402,
    -32'sd503221723,
    32'sd235476951
  };

endpackage

// ===== hdl/tbeq_stream_if.sv =====
interface tbeq_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface tbeq_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ===== hdl/three_band_iir_equalizer_unit.sv =====
// Three-band equalizer: a first-order low pass, a first-order high pass and a
// second-order band pass run in parallel on each sample, and their outputs are
// summed, rounded and saturated to the sample width.
// Samples enter on in_chan_i and leave on out_chan_o, both valid/ready streams;
// a transaction moves one sample. Every input sample yields exactly one output.
// The sample lands in an input register, and combinational multiply, add and
// saturate logic writes the result register, which drives out_chan_o.
// Throughput is one sample per cycle while the receiver keeps ready high, set
// by the combinational recursive multiply-accumulate.
// When the receiver stalls, the result register holds its sample and the input
// register holds the next one; in_chan_i.ready drops only when both are full.
// Coefficients are written over the APB port, one signed Q3.28 word at byte
// address 4*i in the order low numerator, low feedback, high numerator, high
// feedback, band numerator, band first feedback, band second feedback. Any
// such write clears the filter history; write only while the stream is idle.
// Reset loads the default coefficients, clears the history and empties both
// registers.
module three_band_iir_equalizer_unit
  import tbeq_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tbeq_in_if.sink               in_chan_i,
  tbeq_out_if.source            out_chan_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DW       = SAMPLE_BITS + 1;
  localparam int AW       = SAMPLE_BITS + 40;
  localparam int SPLIT    = 20;
  localparam int FF_SHIFT = COEF_FRAC_BITS - Y_FRAC;
  localparam int FB_SHIFT = COEF_FRAC_BITS - SPLIT;
  localparam int PH_W     = COEF_W + Y_W - SPLIT;
  localparam int PL_W     = COEF_W + SPLIT + 1;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (Y_FRAC - 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [AW-1:0]          wide_t;

  // floor(c * d * 2^16 / 2^COEF_FRAC_BITS)
  function automatic wide_t mul_ff(coef_t c, logic signed [DW-1:0] d);
    logic signed [COEF_W+DW-1:0] p;
    p = c * d;
    return AW'(p >>> FF_SHIFT);
  endfunction

  // floor(c * y / 2^COEF_FRAC_BITS), built from two partial products.
  function automatic wide_t mul_fb(coef_t c, acc_t y);
    logic signed [Y_W-SPLIT-1:0] yh;
    logic signed [SPLIT:0]       yl;
    logic signed [PH_W-1:0]      ph;
    logic signed [PL_W-1:0]      pl;
    logic signed [PH_W:0]        s;
    yh = y[Y_W-1:SPLIT];
    yl = {1'b0, y[SPLIT-1:0]};
    ph = c * yh;
    pl = c * yl;
    s  = (PH_W + 1)'(ph) + (PH_W + 1)'(pl >>> SPLIT);
    return AW'(s >>> FB_SHIFT);
  endfunction

  function automatic acc_t sat_acc(wide_t v);
    logic [AW-Y_W:0] top;
    top = v[AW-1:Y_W-1];
    if (top == '0 || top == '1) begin
      return v[Y_W-1:0];
    end else if (v[AW-1]) begin
      return {1'b1, {(Y_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Y_W-1){1'b1}}};
    end
  endfunction

  function automatic sample_t sat_sample(logic signed [SUM_W-1:0] v);
    logic [SUM_W-SAMPLE_BITS:0] top;
    top = v[SUM_W-1:SAMPLE_BITS-1];
    if (top == '0 || top == '1) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  // Configuration registers
  logic [2:0] cfg_idx;
  logic       cfg_hit;
  logic       cfg_wr;
  coef_t      coef_q [NUM_COEFS];

  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_hit = (32'(cfg_idx) < NUM_COEFS);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? coef_q[cfg_idx] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_q[i] <= COEF_RESET[i];
      end
    end else if (cfg_wr) begin
      coef_q[cfg_idx] <= pwdata;
    end
  end

  // Input register and result register
  logic    x_valid_q;
  sample_t x_q;
  logic    out_valid_q;
  sample_t out_q;
  logic    adv;
  logic    in_take;

  assign adv        = x_valid_q && (!out_valid_q || out_chan_o.ready);
  assign in_take    = in_chan_i.valid && in_chan_i.ready;
  assign in_chan_i.ready   = !x_valid_q || adv;
  assign out_chan_o.valid  = out_valid_q;
  assign out_chan_o.sample_out = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_chan_i.ready) begin
        x_valid_q <= in_chan_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Filter history
  sample_t prev_in_q, older_in_q;
  acc_t    low_prev_q, high_prev_q, mid_prev_q, mid_older_q;
  acc_t    yl_d, yh_d, ym_d;
  sample_t out_d;

  always_comb begin
    logic signed [DW-1:0]    sum_d;
    logic signed [DW-1:0]    diff1_d;
    logic signed [DW-1:0]    diff2_d;
    logic signed [SUM_W-1:0] total;
    sum_d   = DW'(x_q) + DW'(prev_in_q);
    diff1_d = DW'(x_q) - DW'(prev_in_q);
    diff2_d = DW'(x_q) - DW'(older_in_q);
    yl_d = sat_acc(mul_ff(coef_q[REG_LOW_NUM], sum_d)
                   - mul_fb(coef_q[REG_LOW_FB], low_prev_q));
    yh_d = sat_acc(mul_ff(coef_q[REG_HIGH_NUM], diff1_d)
                   - mul_fb(coef_q[REG_HIGH_FB], high_prev_q));
    ym_d = sat_acc(mul_ff(coef_q[REG_MID_NUM], diff2_d)
                   - mul_fb(coef_q[REG_MID_FB1], mid_prev_q)
                   - mul_fb(coef_q[REG_MID_FB2], mid_older_q));
    total = SUM_W'(yl_d) + SUM_W'(yh_d) + SUM_W'(ym_d) + ROUND_HALF;
    out_d = sat_sample(total >>> Y_FRAC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_in_q   <= '0;
      older_in_q  <= '0;
      low_prev_q  <= '0;
      high_prev_q <= '0;
      mid_prev_q  <= '0;
      mid_older_q <= '0;
    end else if (cfg_wr) begin
      prev_in_q   <= '0;
      older_in_q  <= '0;
      low_prev_q  <= '0;
      high_prev_q <= '0;
      mid_prev_q  <= '0;
      mid_older_q <= '0;
    end else if (adv) begin
      prev_in_q   <= x_q;
      older_in_q  <= prev_in_q;
      low_prev_q  <= yl_d;
      high_prev_q <= yh_d;
      mid_prev_q  <= ym_d;
      mid_older_q <= mid_prev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan_i.ready && in_chan_i.valid) begin
      x_q <= in_chan_i.sample_in;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  // A coefficient write leaves the whole history cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (prev_in_q == '0 && older_in_q == '0 && low_prev_q == '0 &&
                high_prev_q == '0 && mid_prev_q == '0 && mid_older_q == '0))
    else $error("filter history not cleared after coefficient write");

  // An accepted sample is held in the input register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> x_valid_q)
    else $error("accepted sample lost");

  // A pending sample is not dropped while the result register is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_valid_q && !adv) |=> (x_valid_q && $stable(x_q)))
    else $error("pending sample dropped during stall");

  // The input delay line shifts by one sample on each processed sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !cfg_wr) |=> (older_in_q == $past(prev_in_q) && prev_in_q == $past(x_q)))
    else $error("input history did not shift");

endmodule
